// ===== hw/rtl/mi_pkg.sv =====
package mi_pkg;

  localparam int unsigned DEFAULT_WIDTH = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_TEST,
    S_DIVIDE,
    S_UPDATE,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath. At most one is high per cycle.
  typedef struct packed {
    logic load;
    logic div_step;
    logic reduce_take;
    logic div_init;
    logic euclid_take;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic m_zero;
    logic r1_zero;
  } sts_t;

endpackage

// ===== hw/rtl/modular_inverse_core.sv =====
// Modular inverse by the extended Euclidean algorithm.
// Input channel (in_valid/in_ready) takes one word: value and modulus.
// Output channel (out_valid/out_ready) returns one word per input: inverse,
// in 0 .. modulus-1, and no_inverse, set when the gcd is not 1 or the
// modulus is zero (inverse is then 0).
// One item is worked on at a time. The modulus reduction and each Euclid step
// run on the single restoring divider, which retires one quotient bit per
// cycle. A zero modulus skips the divider and goes straight to finishing.
// The result sits in an output register, so the next word is accepted as
// soon as the current one is written there, even while the receiver stalls.
// A finished item waits in the controller until the output register frees.
// Synchronous reset returns the controller to idle and drops out_valid.
module modular_inverse_core #(
  parameter int unsigned WIDTH = mi_pkg::DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] value,
  input  logic [WIDTH-1:0] modulus,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] inverse,
  output logic             no_inverse
);

  mi_pkg::cmd_t ctl_cmd;
  mi_pkg::sts_t sts;

  mi_ctrl #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (ctl_cmd),
    .sts      (sts)
  );

  mi_dpath #(
    .WIDTH(WIDTH)
  ) u_dpath (
    .clk       (clk),
    .value     (value),
    .modulus   (modulus),
    .cmd       (ctl_cmd),
    .sts       (sts),
    .inverse   (inverse),
    .no_inverse(no_inverse)
  );

endmodule

// ===== hw/rtl/mi_dpath.sv =====
module mi_dpath #(
  parameter int unsigned WIDTH = mi_pkg::DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] value,
  input  logic [WIDTH-1:0] modulus,
  input  mi_pkg::cmd_t     cmd,
  output mi_pkg::sts_t     sts,
  output logic [WIDTH-1:0] inverse,
  output logic             no_inverse
);

  logic [WIDTH-1:0] m;
  logic [WIDTH-1:0] r0;
  logic [WIDTH-1:0] r1;
  logic [WIDTH-1:0] u0;
  logic [WIDTH-1:0] u1;
  logic             par;

  // Restoring divider state: dividend shifts out MSB first into the partial
  // remainder; acc builds quotient * u1 one quotient bit at a time.
  logic [WIDTH-1:0] dvd;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] acc;

  logic [WIDTH:0]   sh;
  logic [WIDTH:0]   diff;
  logic             geq;
  logic [WIDTH-1:0] rem_step;
  logic [WIDTH-1:0] acc_step;

  logic [WIDTH-1:0] u0_red;
  logic             fail;
  logic [WIDTH-1:0] inv_calc;

  always_comb begin
    sh       = {rem, dvd[WIDTH-1]};
    geq      = (sh >= {1'b0, dvs});
    diff     = sh - {1'b0, dvs};
    rem_step = geq ? diff[WIDTH-1:0] : sh[WIDTH-1:0];
    // The true product quotient * u1 never exceeds the modulus, so WIDTH bits hold it.
    acc_step = {acc[WIDTH-2:0], 1'b0} + (geq ? u1 : '0);
  end

  always_comb begin
    u0_red = (u0 == m) ? '0 : u0;
    fail   = sts.m_zero || (r0 != WIDTH'(1));
    // Coefficient signs alternate, so an even step count means a negative coefficient.
    if (par || (u0_red == '0)) begin
      inv_calc = u0_red;
    end else begin
      inv_calc = m - u0_red;
    end
  end

  assign sts.m_zero  = (m == '0);
  assign sts.r1_zero = (r1 == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m   <= modulus;
      dvd <= value;
      dvs <= modulus;
      rem <= '0;
      acc <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[WIDTH-2:0], 1'b0};
      rem <= rem_step;
      acc <= acc_step;
    end else if (cmd.reduce_take) begin
      r0  <= m;
      r1  <= rem;
      u0  <= '0;
      u1  <= WIDTH'(1);
      par <= 1'b0;
    end else if (cmd.div_init) begin
      dvd <= r0;
      dvs <= r1;
      rem <= '0;
      acc <= '0;
    end else if (cmd.euclid_take) begin
      r0  <= r1;
      r1  <= rem;
      u0  <= u1;
      u1  <= u0 + acc;
      par <= ~par;
    end else if (cmd.finish) begin
      no_inverse <= fail;
      inverse    <= fail ? '0 : inv_calc;
    end
  end

endmodule

// ===== hw/rtl/mi_ctrl.sv =====
module mi_ctrl #(
  parameter int unsigned WIDTH = mi_pkg::DEFAULT_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output mi_pkg::cmd_t cmd,
  input  mi_pkg::sts_t sts
);

  localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  mi_pkg::state_t state;
  mi_pkg::state_t state_next;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  cnt_next;
  logic           out_valid_next;
  // The first update after the reduction seeds the Euclid registers instead of
  // advancing them; a flag tells the two apart.
  logic           first_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mi_pkg::S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_upd <= 1'b0;
    end else if (cmd.load) begin
      first_upd <= 1'b1;
    end else if (state == mi_pkg::S_UPDATE) begin
      first_upd <= 1'b0;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      mi_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = CW'(WIDTH - 1);
          state_next = mi_pkg::S_REDUCE;
        end
      end
      mi_pkg::S_REDUCE: begin
        if (sts.m_zero) begin
          state_next = mi_pkg::S_FINISH;
        end else begin
          cmd.div_step = 1'b1;
          cnt_next     = cnt - CW'(1);
          if (cnt == '0) begin
            state_next = mi_pkg::S_UPDATE;
          end
        end
      end
      mi_pkg::S_UPDATE: begin
        if (first_upd) begin
          cmd.reduce_take = 1'b1;
        end else begin
          cmd.euclid_take = 1'b1;
        end
        state_next = mi_pkg::S_TEST;
      end
      mi_pkg::S_TEST: begin
        if (sts.r1_zero) begin
          state_next = mi_pkg::S_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          cnt_next     = CW'(WIDTH - 1);
          state_next   = mi_pkg::S_DIVIDE;
        end
      end
      mi_pkg::S_DIVIDE: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - CW'(1);
        if (cnt == '0) begin
          state_next = mi_pkg::S_UPDATE;
        end
      end
      mi_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = mi_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mi_pkg::S_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result register overwritten while a word is pending");

  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.div_step, cmd.reduce_take, cmd.div_init,
              cmd.euclid_take, cmd.finish}))
    else $error("more than one datapath command in a cycle");

  assert property (@(posedge clk) disable iff (rst)
    (state == mi_pkg::S_DIVIDE) && (cnt == '0) |=> (state == mi_pkg::S_UPDATE))
    else $error("divider did not hand over to the update");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == mi_pkg::S_REDUCE))
    else $error("accepted word did not start the reduction");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned W = mi_pkg::DEFAULT_WIDTH;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  // Longest item is about 46 Euclid steps, each a full pass through the divider.
  localparam int unsigned DRAIN_CYCLES = 1700;
  localparam int unsigned RANDOM_WORDS = 400;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic [W-1:0] value;
    logic [W-1:0] modulus;
    logic [W-1:0] inverse;
    logic         no_inverse;
  } inverse_word_t;

  typedef enum int {
    K_FULL,
    K_SMALL,
    K_SHARED,
    K_PRIME,
    K_TINY_MOD,
    K_WRAPPED,
    K_ODD_MOD,
    K_FIBONACCI
  } stim_kind_t;

  class inverse_scoreboard;
    inverse_word_t expected_q[$];
    int unsigned   mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Extended Euclid on the magnitudes of the Bezout coefficients; their
    // signs alternate, so the parity of the step count picks the sign.
    function void solve_inverse(input logic [W-1:0] a, input logic [W-1:0] m,
                                output logic [W-1:0] inv, output logic flag);
      logic [63:0] r0, r1, r2, u0, u1, u2, q;
      int unsigned steps;
      inv = '0;
      flag = 1'b1;
      if (m != 0) begin
        r0 = 64'(m);
        r1 = 64'(a) % 64'(m);
        u0 = 64'd0;
        u1 = 64'd1;
        steps = 0;
        while (r1 != 0) begin
          q = r0 / r1;
          r2 = r0 - q * r1;
          u2 = u0 + q * u1;
          r0 = r1;
          r1 = r2;
          u0 = u1;
          u1 = u2;
          steps++;
        end
        if (r0 == 64'd1) begin
          u0 = u0 % 64'(m);
          flag = 1'b0;
          if (steps[0] || u0 == 0)
            inv = u0[W-1:0];
          else
            inv = W'(64'(m) - u0);
        end
      end
    endfunction

    function void note_input(input logic [W-1:0] v, input logic [W-1:0] m);
      inverse_word_t exp_word;
      exp_word.value = v;
      exp_word.modulus = m;
      solve_inverse(v, m, exp_word.inverse, exp_word.no_inverse);
      expected_q.push_back(exp_word);
    endfunction

    function void check_result(input logic [W-1:0] inv, input logic flag);
      inverse_word_t exp_word;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result word inverse=%h no_inverse=%b", inv, flag);
      end else begin
        exp_word = expected_q.pop_front();
        if (exp_word.inverse !== inv || exp_word.no_inverse !== flag) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: value=%h modulus=%h expected inverse=%h no_inverse=%b, got %h %b",
                     exp_word.value, exp_word.modulus, exp_word.inverse,
                     exp_word.no_inverse, inv, flag);
        end
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         in_valid = 1'b0;
  logic         in_ready;
  logic [W-1:0] value = '0;
  logic [W-1:0] modulus = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [W-1:0] inverse;
  logic         no_inverse;

  inverse_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned mode_left = 0;
  logic        stall_mode = 1'b0;
  int unsigned cycle_count = 0;

  modular_inverse_core #(
    .WIDTH(W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .modulus(modulus),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .inverse(inverse),
    .no_inverse(no_inverse)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("modular_inverse_core test failed");
      $finish;
    end
  end

  // Receiver: stretches of steady readiness alternate with stretches of
  // random stalls, mostly short and now and then long.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(inverse, no_inverse);
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2) != 0;
      mode_left <= $urandom_range(100, 3000);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_mode && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                 : $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(input logic [W-1:0] v, input logic [W-1:0] m);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 400) : $urandom_range(1, 40))
          @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    value <= v;
    modulus <= m;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    sb.note_input(v, m);
  endtask

  initial begin
    logic [W-1:0] dir_value[$];
    logic [W-1:0] dir_modulus[$];
    logic [W-1:0] v, m;
    logic [63:0]  fa, fb, ft;
    int unsigned  f;
    stim_kind_t   kind;

    // Zero and unit moduli, zero values, wrapped values, shared factors and
    // the consecutive Fibonacci pair that needs the most Euclid steps.
    dir_value   = '{32'd5, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd3,
                    32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd2, 32'd6, 32'd10, 32'd7,
                    32'd1836311903, 32'd2971215073, 32'h8000_0000, 32'd1, 32'd0,
                    32'd3, 32'd65537, 32'd2};
    dir_modulus = '{32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd7, 32'd7,
                    32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd9,
                    32'd7, 32'd7, 32'd2971215073, 32'd1836311903, 32'hFFFF_FFFB,
                    32'd2, 32'd2, 32'd4294967291, 32'd4294967291, 32'd4};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_value[i])
      send_word(dir_value[i], dir_modulus[i]);

    repeat (RANDOM_WORDS) begin
      kind = stim_kind_t'($urandom_range(0, 7));
      case (kind)
        K_FULL: begin
          v = $urandom();
          m = $urandom();
        end
        K_SMALL: begin
          v = $urandom_range(0, 2000);
          m = $urandom_range(1, 1000);
        end
        K_SHARED: begin
          f = $urandom_range(2, 50);
          v = W'(f * $urandom_range(0, 1 << 20));
          m = W'(f * $urandom_range(1, 1 << 20));
        end
        K_PRIME: begin
          v = $urandom();
          case ($urandom_range(0, 3))
            0: m = 32'd4294967291;
            1: m = 32'd2147483647;
            2: m = 32'd65521;
            default: m = 32'd251;
          endcase
        end
        K_TINY_MOD: begin
          v = $urandom();
          m = W'($urandom_range(0, 1));
        end
        K_WRAPPED: begin
          v = $urandom();
          m = $urandom_range(1, 1 << 16);
        end
        K_ODD_MOD: begin
          v = $urandom();
          m = $urandom() | 32'd1;
        end
        default: begin
          fa = 64'd0;
          fb = 64'd1;
          repeat ($urandom_range(2, 46)) begin
            ft = fa + fb;
            fa = fb;
            fb = ft;
          end
          v = fa[W-1:0];
          m = fb[W-1:0];
        end
      endcase
      send_word(v, m);
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0)
      @(posedge clk);
    // Any word arriving after this point has no expectation and is caught.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("modular_inverse_core test passed");
    else
      $display("modular_inverse_core test failed");
    $finish;
  end

endmodule

// ===== modular_inverse_core.f =====
hw/rtl/mi_pkg.sv
hw/rtl/mi_dpath.sv
hw/rtl/mi_ctrl.sv
hw/rtl/modular_inverse_core.sv
tb/sv/tb_top.sv
